// ----- design/assert_macros.svh -----
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks an implication on every clock edge outside of reset.
`define CHECK_PROP(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("Property check failed.");

// Checks a condition that must hold on every clock edge outside of reset.
`define CHECK_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("Invariant check failed.");

`endif

// ----- design/msts_pkg.sv -----
package msts_pkg;

   localparam int ID_W        = 3;
   localparam int OUT_STAMP_W = 48;
   localparam int FRAME_W     = 32;
   localparam int ENABLE_W    = 8;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [ENABLE_W-1:0] ENABLE_RESET = 8'hFF;

   // Word index of each register, taken from the top address bit.
   localparam logic REG_STREAM_ENABLE = 1'b0;

endpackage

// ----- design/multi_stream_timestamp_sync.sv -----
// A request stalls the input while its stamp is pushed (if its stream is enabled) and the
// streams are checked; a frame then scans each enabled stream's queue and emits its entry,
// and a stall on the result side holds it longer.
// Requests are taken one at a time, set by the scan through the one stamp memory read port.
// Reset (synchronous, active high) empties all queues, clears the frame count and enables
// every stream; the stamp memory itself is not cleared.
module multi_stream_timestamp_sync
   import msts_pkg::*;
#(
   parameter int NUM_STREAMS = 8,
   parameter int QUEUE_DEPTH = 16,
   parameter int STAMP_BITS  = 48
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [ID_W-1:0]        req_stream_id,
   input  logic [OUT_STAMP_W-1:0] req_stamp,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [ID_W-1:0]        rsp_out_stream,
   output logic [OUT_STAMP_W-1:0] rsp_chosen_stamp,
   output logic [FRAME_W-1:0]     rsp_frame_number,
   output logic                   rsp_last_of_frame,
   input  logic                   psel,
   input  logic                   penable,
   input  logic                   pwrite,
   input  logic [CSR_ADDR_W-1:0]  paddr,
   input  logic [CSR_DATA_W-1:0]  pwdata,
   output logic [CSR_DATA_W-1:0]  prdata,
   output logic                   pready
);

   localparam int SIW = (NUM_STREAMS > 1) ? $clog2(NUM_STREAMS) : 1;
   localparam int SCW = $clog2(NUM_STREAMS + 1);
   localparam int HW  = $clog2(QUEUE_DEPTH);
   localparam int CW  = $clog2(QUEUE_DEPTH + 1);
   localparam int SBW = STAMP_BITS;

   typedef enum logic [2:0] {
      S_IDLE, S_PUSH, S_CHK, S_CHKW, S_FRM, S_SRD, S_SCMP, S_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic [ENABLE_W-1:0] enable_ff, enable_in;
   logic [SCW-1:0] s_ff, s_in;
   logic [SBW-1:0] stamp_ff, stamp_in;
   logic [SBW-1:0] ft_ff, ft_in;
   logic any_ff, any_in;
   logic [SIW-1:0] last_ff, last_in;
   logic [CW-1:0] j_ff, j_in;
   logic [CW-1:0] best_ff, best_in;
   logic [SBW-1:0] bestd_ff, bestd_in;
   logic [SBW-1:0] bestv_ff, bestv_in;
   logic [FRAME_W-1:0] frames_ff, frames_in;
   logic [HW-1:0] heads_ff [NUM_STREAMS];
   logic [HW-1:0] heads_in [NUM_STREAMS];
   logic [CW-1:0] counts_ff [NUM_STREAMS];
   logic [CW-1:0] counts_in [NUM_STREAMS];
   logic rsp_valid_ff, rsp_valid_in;
   logic [ID_W-1:0] rsp_stream_ff, rsp_stream_in;
   logic [OUT_STAMP_W-1:0] rsp_stamp_ff, rsp_stamp_in;
   logic [FRAME_W-1:0] rsp_frame_ff, rsp_frame_in;
   logic rsp_last_ff, rsp_last_in;

   logic [SBW-1:0] mem [NUM_STREAMS][QUEUE_DEPTH];
   logic [SBW-1:0] rd_ff;

   logic [SIW-1:0] cur;
   logic [HW-1:0] cur_head, push_head, wr_idx, rd_idx;
   logic [CW-1:0] cur_count, push_count;
   logic wr_en, s_on, req_on, out_free;
   logic [SBW-1:0] delta;

   function automatic logic [HW-1:0] wrap_add(input logic [HW-1:0] h, input logic [HW:0] x);
      logic [HW+1:0] sum;
      sum = {2'b00, h} + {1'b0, x};
      if (sum >= (HW+2)'(QUEUE_DEPTH)) begin
         sum = sum - (HW+2)'(QUEUE_DEPTH);
      end
      return sum[HW-1:0];
   endfunction

   assign cur       = s_ff[SIW-1:0];
   assign cur_head  = heads_ff[cur];
   assign cur_count = counts_ff[cur];
   assign s_on      = (s_ff < SCW'(NUM_STREAMS)) && enable_ff[cur];
   assign req_on    = (32'(req_stream_id) < NUM_STREAMS) && enable_ff[req_stream_id];
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign delta     = (rd_ff >= ft_ff) ? (rd_ff - ft_ff) : (ft_ff - rd_ff);

   always_comb begin
      if (cur_count == CW'(QUEUE_DEPTH)) begin
         push_head  = wrap_add(cur_head, (HW+1)'(1));
         push_count = CW'(QUEUE_DEPTH - 1);
      end else begin
         push_head  = cur_head;
         push_count = cur_count;
      end
      wr_idx = wrap_add(push_head, (HW+1)'(push_count));
      wr_en  = (state_ff == S_PUSH);
      if (state_ff == S_CHK) begin
         rd_idx = wrap_add(cur_head, (HW+1)'(cur_count - CW'(1)));
      end else begin
         rd_idx = wrap_add(cur_head, (HW+1)'(j_ff));
      end
   end

   always_comb begin
      state_in      = state_ff;
      enable_in     = enable_ff;
      s_in          = s_ff;
      stamp_in      = stamp_ff;
      ft_in         = ft_ff;
      any_in        = any_ff;
      last_in       = last_ff;
      j_in          = j_ff;
      best_in       = best_ff;
      bestd_in      = bestd_ff;
      bestv_in      = bestv_ff;
      frames_in     = frames_ff;
      heads_in      = heads_ff;
      counts_in     = counts_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_stream_in = rsp_stream_ff;
      rsp_stamp_in  = rsp_stamp_ff;
      rsp_frame_in  = rsp_frame_ff;
      rsp_last_in   = rsp_last_ff;

      if (psel && penable && pwrite && paddr[2] == REG_STREAM_ENABLE) begin
         enable_in = pwdata[ENABLE_W-1:0];
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               stamp_in = SBW'(req_stamp);
               any_in   = 1'b0;
               if (req_on) begin
                  s_in     = SCW'(req_stream_id);
                  state_in = S_PUSH;
               end else begin
                  s_in     = '0;
                  state_in = S_CHK;
               end
            end
         end
         S_PUSH: begin
            heads_in[cur]  = push_head;
            counts_in[cur] = push_count + CW'(1);
            s_in           = '0;
            state_in       = S_CHK;
         end
         S_CHK: begin
            if (s_ff == SCW'(NUM_STREAMS)) begin
               s_in     = '0;
               state_in = any_ff ? S_FRM : S_IDLE;
            end else if (!s_on) begin
               s_in = s_ff + SCW'(1);
            end else if (cur_count == '0) begin
               state_in = S_IDLE;
            end else begin
               state_in = S_CHKW;
            end
         end
         S_CHKW: begin
            if (!any_ff || rd_ff < ft_ff) begin
               ft_in = rd_ff;
            end
            any_in   = 1'b1;
            last_in  = cur;
            s_in     = s_ff + SCW'(1);
            state_in = S_CHK;
         end
         S_FRM: begin
            if (s_ff == SCW'(NUM_STREAMS)) begin
               frames_in = frames_ff + FRAME_W'(1);
               state_in  = S_IDLE;
            end else if (!s_on) begin
               s_in = s_ff + SCW'(1);
            end else begin
               j_in     = '0;
               state_in = S_SRD;
            end
         end
         S_SRD: begin
            state_in = S_SCMP;
         end
         S_SCMP: begin
            if (j_ff == '0 || delta < bestd_ff) begin
               bestd_in = delta;
               bestv_in = rd_ff;
               best_in  = j_ff;
            end
            if (j_ff + CW'(1) < cur_count) begin
               j_in     = j_ff + CW'(1);
               state_in = S_SRD;
            end else begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_stream_in  = ID_W'(cur);
               rsp_stamp_in   = OUT_STAMP_W'(bestv_ff);
               rsp_frame_in   = frames_ff;
               rsp_last_in    = (cur == last_ff);
               heads_in[cur]  = wrap_add(cur_head, (HW+1)'(best_ff) + (HW+1)'(1));
               counts_in[cur] = cur_count - best_ff - CW'(1);
               s_in           = s_ff + SCW'(1);
               state_in       = S_FRM;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         enable_ff     <= ENABLE_RESET;
         s_ff          <= '0;
         stamp_ff      <= '0;
         ft_ff         <= '0;
         any_ff        <= 1'b0;
         last_ff       <= '0;
         j_ff          <= '0;
         best_ff       <= '0;
         bestd_ff      <= '0;
         bestv_ff      <= '0;
         frames_ff     <= '0;
         for (int i = 0; i < NUM_STREAMS; i++) begin
            heads_ff[i]  <= '0;
            counts_ff[i] <= '0;
         end
         rsp_valid_ff  <= 1'b0;
         rsp_stream_ff <= '0;
         rsp_stamp_ff  <= '0;
         rsp_frame_ff  <= '0;
         rsp_last_ff   <= 1'b0;
      end else begin
         state_ff      <= state_in;
         enable_ff     <= enable_in;
         s_ff          <= s_in;
         stamp_ff      <= stamp_in;
         ft_ff         <= ft_in;
         any_ff        <= any_in;
         last_ff       <= last_in;
         j_ff          <= j_in;
         best_ff       <= best_in;
         bestd_ff      <= bestd_in;
         bestv_ff      <= bestv_in;
         frames_ff     <= frames_in;
         heads_ff      <= heads_in;
         counts_ff     <= counts_in;
         rsp_valid_ff  <= rsp_valid_in;
         rsp_stream_ff <= rsp_stream_in;
         rsp_stamp_ff  <= rsp_stamp_in;
         rsp_frame_ff  <= rsp_frame_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[cur][wr_idx] <= stamp_ff;
      end
      rd_ff <= mem[cur][rd_idx];
   end

   assign req_stall         = (state_ff != S_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_stream    = rsp_stream_ff;
   assign rsp_chosen_stamp  = rsp_stamp_ff;
   assign rsp_frame_number  = rsp_frame_ff;
   assign rsp_last_of_frame = rsp_last_ff;
   assign prdata            = CSR_DATA_W'(enable_ff);
   assign pready            = 1'b1;

endmodule

// ----- design/msts_checker.sv -----
`include "assert_macros.svh"

module msts_checker
   import msts_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_stall,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input logic [OUT_STAMP_W-1:0] rsp_chosen_stamp,
   input logic                   psel,
   input logic                   penable,
   input logic                   pready
);

   `CHECK_PROP(busy_after_req, clock, reset, (req_valid && !req_stall) |=> req_stall)
   `CHECK_PROP(rsp_only_while_busy, clock, reset, $rose(rsp_valid) |-> $past(req_stall))
   `CHECK_PROP(rsp_hold, clock, reset, (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_chosen_stamp)))
   `CHECK_ALWAYS(csr_no_wait, clock, reset, !(psel && penable) || pready)

endmodule

bind multi_stream_timestamp_sync msts_checker u_msts_checker (.*);
